// ----- rtl/blr_pkg.sv -----
// Shared types for the line rasterizer: coordinate widths, request codes,
// the input and result words, and the per-line walking state. No dependencies.
package blr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEC_BITS   = COORD_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] dist_t;
    typedef logic signed [DEC_BITS-1:0]   dec_t;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_type_t;

    typedef struct packed {
        req_type_t req_type;
        coord_t    x_start;
        coord_t    y_start;
        coord_t    x_end;
        coord_t    y_end;
    } in_item_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last;
    } out_item_t;

    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        dec_t   decision;
        dist_t  steps_left;
        dist_t  delta_major;
        dist_t  delta_minor;
        logic   y_is_major;
        logic   minor_down;
        logic   active;
    } line_state_t;

endpackage

// ----- rtl/blr_setup.sv -----
// Line setup: absolute deltas, major axis, start point and initial decision term.
// Depends on blr_pkg.
module blr_setup
    import blr_pkg::*;
(
    input  in_item_t    in_item,
    output line_state_t setup_state
);

    logic signed [COORD_BITS:0] sdx;
    logic signed [COORD_BITS:0] sdy;
    logic signed [COORD_BITS:0] neg_dx;
    logic signed [COORD_BITS:0] neg_dy;
    dist_t                      adx;
    dist_t                      ady;
    logic                       y_major;
    logic                       take_end;
    dist_t                      major;
    dist_t                      minor;
    dec_t                       twice_minor;
    dec_t                       major_ext;

    always_comb begin
        sdx    = $signed({in_item.x_end[COORD_BITS-1], in_item.x_end})
               - $signed({in_item.x_start[COORD_BITS-1], in_item.x_start});
        sdy    = $signed({in_item.y_end[COORD_BITS-1], in_item.y_end})
               - $signed({in_item.y_start[COORD_BITS-1], in_item.y_start});
        neg_dx = -sdx;
        neg_dy = -sdy;
        adx    = sdx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : sdx[COORD_BITS-1:0];
        ady    = sdy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : sdy[COORD_BITS-1:0];

        // x wins ties, so diagonals walk along x
        y_major = (adx < ady);
        major   = y_major ? ady : adx;
        minor   = y_major ? adx : ady;

        // begin at the smaller major coordinate, start endpoint on a tie
        take_end = y_major ? (in_item.y_end < in_item.y_start)
                           : (in_item.x_end < in_item.x_start);

        twice_minor = {1'b0, minor, 1'b0};
        major_ext   = {2'b00, major};

        setup_state.cur_x       = take_end ? in_item.x_end : in_item.x_start;
        setup_state.cur_y       = take_end ? in_item.y_end : in_item.y_start;
        setup_state.decision    = twice_minor - major_ext;
        setup_state.steps_left  = major;
        setup_state.delta_major = major;
        setup_state.delta_minor = minor;
        setup_state.y_is_major  = y_major;
        setup_state.minor_down  = (sdx != '0) && (sdy != '0) &&
                                  (sdx[COORD_BITS] != sdy[COORD_BITS]);
        setup_state.active      = (major != '0);
    end

endmodule

// ----- rtl/blr_step.sv -----
// One Bresenham step: advance the major axis, update the decision term and
// move the minor axis when the term is non-negative. Depends on blr_pkg.
module blr_step
    import blr_pkg::*;
(
    input  line_state_t cur_state,
    output line_state_t step_state
);

    dec_t   twice_minor;
    dec_t   twice_major;
    logic   move_minor;
    coord_t major_coord;
    coord_t minor_coord;
    coord_t major_adv;
    coord_t minor_adv;
    dist_t  steps_dec;

    always_comb begin
        twice_minor = {1'b0, cur_state.delta_minor, 1'b0};
        twice_major = {1'b0, cur_state.delta_major, 1'b0};
        move_minor  = !cur_state.decision[DEC_BITS-1];

        major_coord = cur_state.y_is_major ? cur_state.cur_y : cur_state.cur_x;
        minor_coord = cur_state.y_is_major ? cur_state.cur_x : cur_state.cur_y;
        major_adv   = major_coord + coord_t'(1);
        if (!move_minor) begin
            minor_adv = minor_coord;
        end else if (cur_state.minor_down) begin
            minor_adv = minor_coord - coord_t'(1);
        end else begin
            minor_adv = minor_coord + coord_t'(1);
        end

        steps_dec = cur_state.steps_left - dist_t'(1);

        step_state            = cur_state;
        // the term stays inside its width after either update; wrap the sum freely
        step_state.decision   = move_minor
                              ? cur_state.decision + twice_minor - twice_major
                              : cur_state.decision + twice_minor;
        step_state.cur_x      = cur_state.y_is_major ? minor_adv : major_adv;
        step_state.cur_y      = cur_state.y_is_major ? major_adv : minor_adv;
        step_state.steps_left = steps_dec;
        step_state.active     = (steps_dec != '0);
    end

endmodule

// ----- rtl/bresenham_line_rasterizer.sv -----
// Bresenham line rasterizer, top level. Depends on blr_pkg, blr_setup, blr_step.
// Flow: an accepted word waits in the input register until the result register is
// free or draining; its pixel, if any, is then loaded into the result register.
// Throughput: one word per cycle while the result side is not stalled by m_ready.
// Reset (aresetn low, synchronous): both stages empty, no line active, state zeroed.
module bresenham_line_rasterizer
    import blr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // Input stage: holds one accepted word
    logic        in_valid_reg;
    logic        in_valid_next;
    in_item_t    in_item_reg;

    // Line walking state
    line_state_t state_reg;
    line_state_t state_next;
    line_state_t setup_state;
    line_state_t step_state;

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;

    logic        is_start;
    logic        has_result;
    logic        advance;
    logic        s_take;

    blr_setup u_setup (
        .in_item     (in_item_reg),
        .setup_state (setup_state)
    );

    blr_step u_step (
        .cur_state  (state_reg),
        .step_state (step_state)
    );

    always_comb begin
        is_start   = (in_item_reg.req_type == REQ_START);
        // a step with no line in progress is consumed silently
        has_result = is_start || state_reg.active;
        // move the input word on once the result register is free or draining
        advance    = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready    = !in_valid_reg || advance;
        s_take     = s_valid && s_ready;

        // a start drops whatever line was in progress
        if (is_start) begin
            state_next = setup_state;
        end else if (state_reg.active) begin
            state_next = step_state;
        end else begin
            state_next = state_reg;
        end

        // emit the pixel the state lands on; last when nothing is left to walk
        out_item_next.pixel_x = state_next.cur_x;
        out_item_next.pixel_y = state_next.cur_y;
        out_item_next.last    = (state_next.steps_left == '0);

        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance && has_result) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: load only, no reset
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
        if (advance && has_result) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

// ----- rtl/blr_checker.sv -----
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer.
module blr_checker
    import blr_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result word changed or dropped while stalled");

    // reset leaves both stages empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    // input may only stall behind a stalled result word
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled while result side can move");

    // a result word leaves only when taken
    a_out_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result word withdrawn without handshake");

    // a stalled input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input word changed or dropped while stalled");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);
